>>> hw/rtl/oale_pkg.sv
// Shared types and constants for the ordered array list engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package oale_pkg;
    localparam int CAPACITY     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int KEY_W        = 64;
    localparam int ENTRY_W      = KEY_W + PAYLOAD_BITS;
    localparam int QDEPTH       = 2;

    typedef enum logic [2:0] {
        ACT_INSERT    = 3'd0,
        ACT_DELETE    = 3'd1,
        ACT_READ      = 3'd2,
        ACT_OVERWRITE = 3'd3,
        ACT_FIND      = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // Command as it leaves the front part.
    typedef struct packed {
        logic [2:0]              action;
        logic [4:0]              position;
        logic                    at_end;
        logic [KEY_W-1:0]        key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_cmd;

    typedef struct packed {
        logic [2:0]              status;
        logic [4:0]              position;
        logic [KEY_W-1:0]        key;
        logic [31:0]             payload;
        logic [5:0]              count;
        logic                    empty;
    } t_res;
endpackage
`default_nettype wire

>>> hw/rtl/oale_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module oale_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/oale_front.sv
// Front part: accepts command beats and queues them for the back part.
// Depends on oale_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oale_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire oale_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output oale_pkg::t_cmd      o_cmd
);
    import oale_pkg::*;

    t_cmd       r_q [QDEPTH];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_n;
    logic       push, pop;

    assign o_ready = (r_n != 2'(QDEPTH));
    assign o_valid = (r_n != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n  <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_n <= r_n + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/oale_back.sv
// Back part: carries out one command at a time over the entry RAM.
// Depends on oale_pkg and oale_ram.
`timescale 1ns / 1ps
`default_nettype none
module oale_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire oale_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output oale_pkg::t_res      o_res
);
    import oale_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_RD    = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_USE   = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state           r_st;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_q;     // walking index
    logic [IDX_W-1:0] r_pos;
    logic [ENTRY_W-1:0] r_hold;
    logic             r_ovalid;
    t_res             r_res;

    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [ENTRY_W-1:0] wdata, rdata;

    oale_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    assign o_ready = (r_st == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    logic [CNT_W-1:0] ins_pos;
    assign ins_pos = r_cmd.at_end ? r_cnt : CNT_W'(r_cmd.position);

    // RAM control: S_RD issues reads, S_PUT writes.
    always_comb begin
        we    = 1'b0;
        addr  = r_q[IDX_W-1:0];
        wdata = r_hold;
        if (r_st == S_PUT) begin
            we = 1'b1;
        end
    end

    task automatic finish(input logic [2:0] st, input logic [4:0] p,
                          input logic [ENTRY_W-1:0] e, input logic [CNT_W-1:0] c);
        r_res.status   <= st;
        r_res.position <= p;
        r_res.key      <= e[ENTRY_W-1 -: KEY_W];
        r_res.payload  <= 32'(e[PAYLOAD_BITS-1:0]);
        r_res.count    <= 6'(c);
        r_res.empty    <= (c == '0);
        r_ovalid       <= 1'b1;
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd <= i_cmd;
                        r_st  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_st <= S_IDLE;
                    case (r_cmd.action)
                        ACT_INSERT: begin
                            if (r_cnt >= CNT_W'(CAPACITY)) begin
                                finish(ST_FULL, '0, '0, r_cnt);
                            end else if (ins_pos > r_cnt) begin
                                finish(ST_BADPOS, '0, '0, r_cnt);
                            end else begin
                                r_pos <= ins_pos[IDX_W-1:0];
                                r_hold <= {r_cmd.key, r_cmd.payload};
                                // shift from the top down, one entry per pass
                                r_st  <= (r_cnt == ins_pos) ? S_PUT : S_RD;
                                if (r_cnt != ins_pos) r_q <= r_cnt - 1'b1;
                                else r_q <= r_cnt;
                            end
                        end
                        ACT_DELETE, ACT_READ, ACT_OVERWRITE: begin
                            if (r_cnt == '0) begin
                                finish(ST_EMPTY, '0, '0, r_cnt);
                            end else if (CNT_W'(r_cmd.position) >= r_cnt) begin
                                finish(ST_BADPOS, '0, '0, r_cnt);
                            end else begin
                                r_pos <= r_cmd.position[IDX_W-1:0];
                                if (r_cmd.action == ACT_OVERWRITE) begin
                                    r_q    <= CNT_W'(r_cmd.position);
                                    r_hold <= {r_cmd.key, r_cmd.payload};
                                    r_st   <= S_PUT;
                                end else if (r_cmd.action == ACT_READ) begin
                                    r_q  <= CNT_W'(r_cmd.position);
                                    r_st <= S_RD;
                                end else if (CNT_W'(r_cmd.position) + 1'b1 == r_cnt) begin
                                    r_cnt <= r_cnt - 1'b1;
                                    finish(ST_OK, r_cmd.position, '0, r_cnt - 1'b1);
                                end else begin
                                    r_q  <= CNT_W'(r_cmd.position) + 1'b1;
                                    r_st <= S_RD;
                                end
                            end
                        end
                        ACT_FIND: begin
                            if (r_cnt == '0) begin
                                finish(ST_EMPTY, '0, '0, r_cnt);
                            end else begin
                                r_q  <= '0;
                                r_st <= S_RD;
                            end
                        end
                        default: finish(ST_BADPOS, '0, '0, r_cnt);
                    endcase
                end
                S_RD:   r_st <= S_WAIT;
                S_WAIT: r_st <= S_USE;
                S_USE: begin
                    r_st <= S_IDLE;
                    case (r_cmd.action)
                        ACT_INSERT: begin
                            // write read entry one slot up
                            r_hold <= rdata;
                            r_q    <= r_q + 1'b1;
                            r_st   <= S_PUT;
                        end
                        ACT_DELETE: begin
                            r_hold <= rdata;
                            r_q    <= r_q - 1'b1;
                            r_st   <= S_PUT;
                        end
                        ACT_READ: finish(ST_OK, 5'(r_pos), rdata, r_cnt);
                        default: begin
                            if (rdata[ENTRY_W-1 -: KEY_W] == r_cmd.key) begin
                                finish(ST_OK, 5'(r_q), rdata, r_cnt);
                            end else if (r_q + 1'b1 >= r_cnt) begin
                                finish(ST_NOTFOUND, '0, '0, r_cnt);
                            end else begin
                                r_q  <= r_q + 1'b1;
                                r_st <= S_RD;
                            end
                        end
                    endcase
                end
                S_PUT: begin
                    r_st <= S_IDLE;
                    case (r_cmd.action)
                        ACT_INSERT: begin
                            if (r_q == CNT_W'(r_pos)) begin
                                r_cnt <= r_cnt + 1'b1;
                                finish(ST_OK, 5'(r_pos), '0, r_cnt + 1'b1);
                            end else if (r_q - 1'b1 == CNT_W'(r_pos)) begin
                                r_q    <= CNT_W'(r_pos);
                                r_hold <= {r_cmd.key, r_cmd.payload};
                                r_st   <= S_PUT;
                            end else begin
                                r_q  <= r_q - 2'd2;
                                r_st <= S_RD;
                            end
                        end
                        ACT_DELETE: begin
                            if (r_q + 2'd2 >= r_cnt) begin
                                r_cnt <= r_cnt - 1'b1;
                                finish(ST_OK, 5'(r_pos), '0, r_cnt - 1'b1);
                            end else begin
                                r_q  <= r_q + 2'd2;
                                r_st <= S_RD;
                            end
                        end
                        default: finish(ST_OK, 5'(r_pos), '0, r_cnt);
                    endcase
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/ordered_array_list_engine.sv
// Top level of the ordered array list engine.
// Depends on oale_pkg, oale_front, oale_back.
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to 32 entries (64-bit key, 32-bit payload) in one RAM.
// A two-beat command queue decouples the input from the executing sequencer.
// Read and overwrite each make one access to the RAM; insert and delete
// move one entry at a time through the single RAM port; find scans the
// entries from the first until the first match. One result per command,
// held in an output register until taken; the sequencer takes no new
// command while it waits.
module ordered_array_list_engine (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: action[2:0], position[7:3], at_end[8], item_key[72:9],
    //        item_payload[104:73], zero fill to 112
    input  wire logic [111:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: status[2:0], result_position[7:3], entry_key[71:8],
    //        entry_payload[103:72], entry_count[109:104], list_empty[110], zero
    output logic      [111:0] m_axis_tdata
);
    import oale_pkg::*;

    t_cmd in_cmd, q_cmd;
    t_res res;
    logic q_valid, q_ready;

    assign in_cmd.action   = s_axis_tdata[2:0];
    assign in_cmd.position = s_axis_tdata[7:3];
    assign in_cmd.at_end   = s_axis_tdata[8];
    assign in_cmd.key      = s_axis_tdata[72:9];
    assign in_cmd.payload  = s_axis_tdata[104:73];

    oale_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    oale_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {1'b0, res.empty, res.count, res.payload, res.key,
                           res.position, res.status};

    logic unused;
    assign unused = ^s_axis_tdata[111:105];
endmodule
`default_nettype wire
